>>> rtl/core/ihsv_pkg.sv
package ihsv_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [63:0] word_t;
    typedef logic [2:0]  status_t;

    // Status codes reported with the last byte of a block.
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_SHORT     = 3'd1;
    localparam status_t ST_MAGIC     = 3'd2;
    localparam status_t ST_SIZE      = 3'd3;
    localparam status_t ST_CAPTION   = 3'd4;
    localparam status_t ST_TAGS      = 3'd5;
    localparam status_t ST_TRUNCATED = 3'd6;

    typedef struct packed {
        byte_t data_byte;
        logic  final_byte;
    } item_t;

    typedef struct packed {
        byte_t   pixel_byte;
        logic    pixel_valid;
        logic    block_done;
        status_t status;
        word_t   image_width;
        word_t   image_height;
    } result_t;

endpackage

>>> rtl/core/ihsv_if.sv
interface ihsv_byte_if;
    import ihsv_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
    modport monitor (input valid, input data_byte, input final_byte, input ready);
endinterface

interface ihsv_result_if;
    import ihsv_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   pixel_byte;
    logic    pixel_valid;
    logic    block_done;
    status_t status;
    word_t   image_width;
    word_t   image_height;

    modport source (output valid, output pixel_byte, output pixel_valid, output block_done,
                    output status, output image_width, output image_height, input ready);
    modport sink (input valid, input pixel_byte, input pixel_valid, input block_done,
                  input status, input image_width, input image_height, output ready);
    modport monitor (input valid, input pixel_byte, input pixel_valid, input block_done,
                     input status, input image_width, input image_height, input ready);
endinterface

>>> rtl/core/ihsv_parse.sv
module ihsv_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ihsv_pkg::item_t  item,
    output logic             res_valid,
    output ihsv_pkg::result_t res
);
    import ihsv_pkg::*;

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_WORDS   = 3'd1;
    localparam logic [2:0] PH_CAPTION = 3'd2;
    localparam logic [2:0] PH_TAGS    = 3'd3;
    localparam logic [2:0] PH_PIXELS  = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;
    // First caption byte, with the size comparison still to be made.
    localparam logic [2:0] PH_CHECK   = 3'd7;

    localparam byte_t MAGIC_BYTES [4] = '{8'h43, 8'h49, 8'h46, 8'h46};
    localparam byte_t NEWLINE         = 8'h0A;
    localparam byte_t TERMINATOR      = 8'h00;
    localparam word_t FIXED_HDR_LEN   = 64'd36;
    localparam logic [5:0] LAST_WORD_OFFSET = 6'd35;
    localparam logic [5:0] WORDS_START      = 6'd4;

    localparam logic [1:0] SEL_HDR_LEN = 2'd0;
    localparam logic [1:0] SEL_CONTENT = 2'd1;
    localparam logic [1:0] SEL_WIDTH   = 2'd2;

    logic [2:0] phase_reg, phase_next;
    word_t      offset_reg, offset_next;
    word_t      hdr_len_reg, hdr_len_next;
    word_t      content_reg, content_next;
    word_t      width_reg, width_next;
    word_t      height_reg, height_next;
    word_t      w3_reg, w3_next;        // 3 * width, modulo 2^64
    word_t      prod_reg, prod_next;    // 3 * width * height, modulo 2^64
    word_t      remain_reg, remain_next;
    status_t    err_reg, err_next;

    byte_t       b;
    logic        fin;
    logic        pix;
    logic [5:0]  rel;
    logic [5:0]  shamt;
    logic [1:0]  sel;
    word_t       ins;
    logic [9:0]  b3;
    logic [71:0] part_full;
    word_t       offset_inc;
    logic        caption_bad;
    logic        tags_end;
    status_t     st;

    assign b   = item.data_byte;
    assign fin = item.final_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_len_next = hdr_len_reg;
        content_next = content_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        w3_next      = w3_reg;
        prod_next    = prod_reg;
        remain_next  = remain_reg;
        err_next     = err_reg;
        pix          = 1'b0;
        st           = ST_OK;

        rel        = offset_reg[5:0] - WORDS_START;
        shamt      = {rel[2:0], 3'b000};
        sel        = rel[4:3];
        ins        = {56'd0, b} << shamt;
        b3         = {2'b00, b} + {1'b0, b, 1'b0};
        part_full  = {8'd0, w3_reg} * {64'd0, b};
        offset_inc = offset_reg + 64'd1;

        caption_bad = (hdr_len_reg < 64'd2) || (offset_reg > (hdr_len_reg - 64'd2));
        tags_end    = offset_inc >= hdr_len_reg;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (b != MAGIC_BYTES[offset_reg[1:0]])
                begin
                    phase_next = PH_ERROR;
                    err_next   = ST_MAGIC;
                end
                else if (offset_reg[1:0] == 2'd3)
                begin
                    phase_next = PH_WORDS;
                end
            end
            PH_WORDS:
            begin
                case (sel)
                    SEL_HDR_LEN: hdr_len_next = hdr_len_reg | ins;
                    SEL_CONTENT: content_next = content_reg | ins;
                    SEL_WIDTH:
                    begin
                        width_next = width_reg | ins;
                        w3_next    = w3_reg + ({54'd0, b3} << shamt);
                    end
                    default:
                    begin
                        height_next = height_reg | ins;
                        prod_next   = prod_reg + (part_full[63:0] << shamt);
                    end
                endcase
                if (offset_reg[5:0] == LAST_WORD_OFFSET)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                if (content_reg != prod_reg)
                begin
                    phase_next = PH_ERROR;
                    err_next   = ST_SIZE;
                end
                else if (caption_bad)
                begin
                    phase_next = PH_ERROR;
                    err_next   = ST_CAPTION;
                end
                else if (b == NEWLINE)
                begin
                    phase_next = PH_TAGS;
                end
                else
                begin
                    phase_next = PH_CAPTION;
                end
            end
            PH_CAPTION:
            begin
                if (caption_bad)
                begin
                    phase_next = PH_ERROR;
                    err_next   = ST_CAPTION;
                end
                else if (b == NEWLINE)
                begin
                    phase_next = PH_TAGS;
                end
            end
            PH_TAGS:
            begin
                if (tags_end)
                begin
                    if (b != TERMINATOR)
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ST_TAGS;
                    end
                    else
                    begin
                        phase_next  = (content_reg == 64'd0) ? PH_DONE : PH_PIXELS;
                        remain_next = content_reg;
                    end
                end
            end
            PH_PIXELS:
            begin
                pix         = 1'b1;
                remain_next = remain_reg - 64'd1;
                if (remain_reg == 64'd1)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        offset_next = (offset_reg == '1) ? offset_reg : offset_inc;

        if (offset_reg < FIXED_HDR_LEN)
        begin
            st = ST_SHORT;
        end
        else if (phase_next == PH_ERROR)
        begin
            st = err_next;
        end
        else if (phase_next != PH_DONE)
        begin
            st = ST_TRUNCATED;
        end

        res_valid        = take && (pix || fin);
        res.pixel_byte   = pix ? b : 8'd0;
        res.pixel_valid  = pix;
        res.block_done   = fin;
        res.status       = fin ? st : ST_OK;
        res.image_width  = fin ? width_next : 64'd0;
        res.image_height = fin ? height_next : 64'd0;

        // The final byte of a block returns everything to the reset state.
        if (fin)
        begin
            phase_next   = PH_MAGIC;
            offset_next  = 64'd0;
            hdr_len_next = 64'd0;
            content_next = 64'd0;
            width_next   = 64'd0;
            height_next  = 64'd0;
            w3_next      = 64'd0;
            prod_next    = 64'd0;
            remain_next  = 64'd0;
            err_next     = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            offset_reg  <= 64'd0;
            hdr_len_reg <= 64'd0;
            content_reg <= 64'd0;
            width_reg   <= 64'd0;
            height_reg  <= 64'd0;
            w3_reg      <= 64'd0;
            prod_reg    <= 64'd0;
            remain_reg  <= 64'd0;
            err_reg     <= ST_OK;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            hdr_len_reg <= hdr_len_next;
            content_reg <= content_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            w3_reg      <= w3_next;
            prod_reg    <= prod_next;
            remain_reg  <= remain_next;
            err_reg     <= err_next;
        end
    end

endmodule

>>> rtl/core/ihsv_outbuf.sv
module ihsv_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  ihsv_pkg::result_t    res,
    output logic                 space,
    ihsv_result_if.source        result_ch
);
    import ihsv_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    fire;

    assign fire  = out_valid_reg && result_ch.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !fire)
        begin
            // Output is stalled: park a new result in the skid stage.
            if (res_valid)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.pixel_byte   = out_reg.pixel_byte;
    assign result_ch.pixel_valid  = out_reg.pixel_valid;
    assign result_ch.block_done   = out_reg.block_done;
    assign result_ch.status       = out_reg.status;
    assign result_ch.image_width  = out_reg.image_width;
    assign result_ch.image_height = out_reg.image_height;

endmodule

>>> rtl/core/image_header_stream_validator.sv
// Channel     Role    Payload
// byte_ch     sink    data_byte[7:0], final_byte
// result_ch   source  pixel_byte[7:0], pixel_valid, block_done, status[2:0],
//                     image_width[63:0], image_height[63:0]
//
// A byte is taken every cycle while byte_ch is ready; its result, if any, is
// registered in the output register, or the skid register on a stall. Header
// state updates in the same cycle the byte is taken, so one update step sets
// the rate. A two-entry output buffer keeps byte_ch ready while one result
// waits; ready drops only when both are full. Reset clears all header state.
module image_header_stream_validator (
    input  logic          clk,
    input  logic          rst_n,
    ihsv_byte_if.sink     byte_ch,
    ihsv_result_if.source result_ch
);
    import ihsv_pkg::*;

    logic    take;
    logic    space;
    logic    res_valid;
    item_t   item;
    result_t res;

    assign byte_ch.ready   = space;
    assign take            = byte_ch.valid && space;
    assign item.data_byte  = byte_ch.data_byte;
    assign item.final_byte = byte_ch.final_byte;

    ihsv_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ihsv_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .result_ch (result_ch)
    );

endmodule

>>> rtl/core/ihsv_checker.sv
module ihsv_checker (
    input  logic          clk,
    input  logic          rst_n,
    ihsv_byte_if.sink     byte_ch,
    ihsv_result_if.source result_ch
);
    import ihsv_pkg::*;

    // Every result is either a pixel word or the end of a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.pixel_valid || result_ch.block_done))
        else $error("result carries neither pixel nor block end");

    // Status and dimensions are zero except on the block end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.block_done) |->
            (result_ch.status == ST_OK && result_ch.image_width == 64'd0 &&
             result_ch.image_height == 64'd0))
        else $error("status or size shown without block end");

    // A non-pixel result carries a zero pixel byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.pixel_valid) |-> (result_ch.pixel_byte == 8'd0))
        else $error("pixel byte nonzero without pixel_valid");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.ready) |=>
            (result_ch.valid && $stable(result_ch.pixel_byte) &&
             $stable(result_ch.status) && $stable(result_ch.block_done)))
        else $error("stalled result changed");

endmodule

bind image_header_stream_validator ihsv_checker u_ihsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
);
